[src/gnde_pkg.sv]
// types, constants and decode helpers shared by the gate netlist evaluator
package gnde_pkg;

    localparam int WIRE_SLOTS  = 1024;
    localparam int SIGNAL_BITS = 16;
    localparam int SLOT_BITS   = $clog2(WIRE_SLOTS);
    localparam int ID_BITS     = 10;
    localparam int IMM_BITS    = 16;
    localparam int OUT_BITS    = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SIGNAL_BITS-1:0] sig_t;
    typedef logic [SLOT_BITS-1:0]   slot_t;

    typedef enum logic [2:0] {
        OP_NOT     = 3'd0,
        OP_AND     = 3'd1,
        OP_OR      = 3'd2,
        OP_LSHIFT  = 3'd3,
        OP_RSHIFT  = 3'd4,
        OP_COPY    = 3'd5,
        OP_IMM_AND = 3'd6,
        OP_IMM_SET = 3'd7
    } gate_op_t;

    typedef enum logic {
        REQ_GATE = 1'b0,
        REQ_READ = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [0:0]          req_type;
        logic [2:0]          gate_op;
        logic [ID_BITS-1:0]  wire_a;
        logic [ID_BITS-1:0]  wire_b;
        logic [ID_BITS-1:0]  wire_dest;
        logic [IMM_BITS-1:0] immediate;
    } req_t;

    typedef struct packed {
        logic [0:0]          resolved;
        logic [OUT_BITS-1:0] wire_value;
    } rsp_t;

    typedef struct packed {
        logic     is_read;
        gate_op_t op;
        logic     need_a;
        logic     need_b;
        slot_t    slot_a;
        slot_t    slot_b;
        slot_t    slot_dest;
        sig_t     imm;
    } entry_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } back_state_t;

    // wire slot count is a power of two, so the modulo is the low bits
    function automatic slot_t slot_of(input logic [ID_BITS-1:0] id);
        slot_of = slot_t'(id);
    endfunction

endpackage

[src/gnde_front.sv]
// request intake: decode of operand needs and a short queue toward the execute side
module gnde_front
    import gnde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_t      req,
    input  back_ctl_t ctl,
    output logic      head_valid,
    output entry_t    head
);

    entry_t                 queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QCNT_BITS-1:0]   count_next;
    logic                   push;
    logic                   pop;
    entry_t                 decoded;

    always_comb
    begin
        decoded.is_read   = (req.req_type == REQ_READ);
        decoded.op        = gate_op_t'(req.gate_op);
        decoded.slot_a    = slot_of(req.wire_a);
        decoded.slot_b    = slot_of(req.wire_b);
        decoded.slot_dest = slot_of(req.wire_dest);
        decoded.imm       = sig_t'(req.immediate);
        decoded.need_a    = 1'b0;
        decoded.need_b    = 1'b0;
        if (req.req_type == REQ_READ)
        begin
            decoded.need_a = 1'b1;
        end
        else
        begin
            case (gate_op_t'(req.gate_op))
                OP_NOT, OP_LSHIFT, OP_RSHIFT, OP_COPY:
                begin
                    decoded.need_a = 1'b1;
                end
                OP_AND, OP_OR:
                begin
                    decoded.need_a = 1'b1;
                    decoded.need_b = 1'b1;
                end
                OP_IMM_AND:
                begin
                    decoded.need_b = 1'b1;
                end
                default:
                begin
                    decoded.need_a = 1'b0;
                end
            endcase
        end
    end

    assign req_stall  = ctl.clearing || (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign push       = req_valid && !req_stall;
    assign pop        = ctl.pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_BITS'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_BITS'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[src/gnde_back.sv]
// execute side: wire file with set flags, gate evaluation and result register
module gnde_back
    import gnde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  entry_t    head,
    output back_ctl_t ctl,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_t      rsp
);

    logic [SIGNAL_BITS:0] wire_mem [WIRE_SLOTS];

    back_state_t          state_reg;
    back_state_t          state_next;
    slot_t                clr_reg;
    slot_t                clr_next;
    entry_t               entry_reg;
    logic [SIGNAL_BITS:0] rd_a_reg;
    logic [SIGNAL_BITS:0] rd_b_reg;
    logic                 rd_en;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    rsp_t                 out_word_reg;
    rsp_t                 out_word_next;
    logic                 wr_en;
    slot_t                wr_addr;
    logic [SIGNAL_BITS:0] wr_data;
    logic                 set_a;
    logic                 set_b;
    sig_t                 va;
    sig_t                 vb;
    sig_t                 result;
    logic                 ok;
    logic                 out_free;

    assign set_a    = rd_a_reg[SIGNAL_BITS];
    assign set_b    = rd_b_reg[SIGNAL_BITS];
    assign va       = rd_a_reg[SIGNAL_BITS-1:0];
    assign vb       = rd_b_reg[SIGNAL_BITS-1:0];
    assign ok       = (!entry_reg.need_a || set_a) && (!entry_reg.need_b || set_b);
    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        case (entry_reg.op)
            OP_NOT:     result = ~va;
            OP_AND:     result = va & vb;
            OP_OR:      result = va | vb;
            OP_LSHIFT:  result = va << entry_reg.imm;
            OP_RSHIFT:  result = va >> entry_reg.imm;
            OP_COPY:    result = va;
            OP_IMM_AND: result = entry_reg.imm & vb;
            default:    result = entry_reg.imm;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = entry_reg.slot_dest;
        wr_data        = {1'b1, result};
        out_valid_next = out_valid_reg && rsp_stall;
        out_word_next  = out_word_reg;
        ctl.pop        = 1'b0;
        ctl.clearing   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clearing = 1'b1;
                wr_en        = 1'b1;
                wr_addr      = clr_reg;
                wr_data      = '0;
                clr_next     = slot_t'(clr_reg + 1'b1);
                if (clr_reg == slot_t'(WIRE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    ctl.pop    = 1'b1;
                    rd_en      = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (entry_reg.is_read)
                    begin
                        out_word_next.resolved   = set_a;
                        out_word_next.wire_value = set_a ? OUT_BITS'(va) : '0;
                    end
                    else if (ok)
                    begin
                        wr_en                    = 1'b1;
                        out_word_next.resolved   = 1'b1;
                        out_word_next.wire_value = OUT_BITS'(result);
                    end
                    else
                    begin
                        out_word_next.resolved   = 1'b0;
                        out_word_next.wire_value = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        if (rd_en)
        begin
            entry_reg <= head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wire_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= wire_mem[head.slot_a];
            rd_b_reg <= wire_mem[head.slot_b];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

endmodule

[src/gate_netlist_dataflow_evaluator.sv]
// top level of the gate netlist evaluator: intake queue and execute side
//
// Holds 1024 wires of 16 bits, each with a set flag, and answers every request
// word with one response word. A gate request is evaluated and written when
// all of its sources are set, else answered as deferred (resolved 0, value 0)
// with nothing changed; a read request returns the set flag and the value, 0
// when unset. In the execute side each request first gets the registered
// two-port read of the wire file, then is evaluated, written back and loaded
// into the response register once that is free; the intake queue holds two
// requests meanwhile. After reset a clearing pass over all 1024 wires resets
// the set flags, one wire a cycle, and requests are stalled until it ends.
module gate_netlist_dataflow_evaluator
    import gnde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    back_ctl_t ctl;
    logic      head_valid;
    entry_t    head;

    gnde_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .ctl        (ctl),
        .head_valid (head_valid),
        .head       (head)
    );

    gnde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .ctl        (ctl),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule
